### sv/trial_division_prime_test_top_macros.svh
// Assertion macros shared by the checker file of the prime tester.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define TDPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define TDPT_ASSERT_CLK(label, prop, msg) \
  `TDPT_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

### sv/tdpt_pkg.sv
// Package of the trial-division prime tester: widths, result codes and link types.
`default_nettype none
package tdpt_pkg;

  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned SQ_WIDTH    = VALUE_WIDTH + 1;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] COUNT_ZERO  = 2'd0;
  localparam logic [1:0] COUNT_ONE   = 2'd1;
  localparam logic [1:0] COUNT_PRIME = 2'd2;
  localparam logic [1:0] COUNT_CAP   = 2'd3;

  // Request from the sequencer to the remainder unit.
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } mod_req_t;

  // Status back from the remainder unit.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

  // Finished result offered by the sequencer.
  typedef struct packed {
    logic       valid;
    logic       is_prime;
    logic [1:0] count;
  } result_t;

endpackage
`default_nettype wire

### sv/tdpt_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module tdpt_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tdpt_pkg::mod_req_t req_i,
  output tdpt_pkg::mod_rsp_t     rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [tdpt_pkg::CNT_WIDTH-1:0]      cnt_q, cnt_d;
  logic [tdpt_pkg::VALUE_WIDTH-1:0]    sh_q, sh_d;
  logic [tdpt_pkg::VALUE_WIDTH-1:0]    rem_q, rem_d;
  logic [tdpt_pkg::VALUE_WIDTH-1:0]    div_q, div_d;
  logic [tdpt_pkg::VALUE_WIDTH:0]      trial;
  logic [tdpt_pkg::VALUE_WIDTH:0]      diff;
  logic                                ge;

  // Shift the next dividend bit into the partial remainder, subtract if it fits.
  assign trial = {rem_q, sh_q[tdpt_pkg::VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tdpt_pkg::CNT_WIDTH'(tdpt_pkg::VALUE_WIDTH);
      sh_d   = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      sh_d  = {sh_q[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
      rem_d = ge ? diff[tdpt_pkg::VALUE_WIDTH-1:0] : trial[tdpt_pkg::VALUE_WIDTH-1:0];
      if (cnt_q == tdpt_pkg::CNT_WIDTH'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

### sv/tdpt_seq.sv
// Sequencer: steps trial divisors up to the square root and forms the result.
`default_nettype none
module tdpt_seq (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate_i,
  input  wire logic                             take_i,
  output logic                                  idle_o,
  output tdpt_pkg::result_t                     res_o,
  output tdpt_pkg::mod_req_t                    req_o,
  input  wire tdpt_pkg::mod_rsp_t               rsp_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                            state_q;
  logic [1:0]                        count_q;
  logic [tdpt_pkg::VALUE_WIDTH-1:0]  n_q;
  logic [tdpt_pkg::VALUE_WIDTH-1:0]  d_q;
  logic [tdpt_pkg::SQ_WIDTH-1:0]     sq_q;
  logic                              sq_over;

  // Divisor square exceeds the candidate: no more divisors to try.
  assign sq_over = sq_q > {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (n_q <= tdpt_pkg::VALUE_WIDTH'(1) || sq_over) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (rsp_i.done) begin
            state_q <= rsp_i.rem_zero ? ST_DONE : ST_CHECK;
          end
        end
        ST_DONE: begin
          if (take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        n_q  <= candidate_i;
        d_q  <= tdpt_pkg::VALUE_WIDTH'(2);
        sq_q <= tdpt_pkg::SQ_WIDTH'(4);
      end
      ST_CHECK: begin
        if (n_q == '0) begin
          count_q <= tdpt_pkg::COUNT_ZERO;
        end else if (n_q == tdpt_pkg::VALUE_WIDTH'(1)) begin
          count_q <= tdpt_pkg::COUNT_ONE;
        end else begin
          count_q <= tdpt_pkg::COUNT_PRIME;
        end
      end
      ST_RUN: begin
        if (rsp_i.done) begin
          if (rsp_i.rem_zero) begin
            count_q <= tdpt_pkg::COUNT_CAP;
          end
          // Advance: (d+1)^2 = d^2 + 2d + 1.
          sq_q <= sq_q + {d_q, 1'b1};
          d_q  <= d_q + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign idle_o         = (state_q == ST_IDLE);
  assign res_o.valid    = (state_q == ST_DONE);
  assign res_o.is_prime = (count_q == tdpt_pkg::COUNT_PRIME);
  assign res_o.count    = count_q;

  assign req_o.start    = (state_q == ST_CHECK) && (n_q > tdpt_pkg::VALUE_WIDTH'(1)) && !sq_over;
  assign req_o.dividend = n_q;
  assign req_o.divisor  = d_q;

endmodule
`default_nettype wire

### sv/trial_division_prime_test_top.sv
// Usage: trial-division prime tester for unsigned 16-bit candidates.
// Input channel: in_valid_i / in_stall_o with candidate_i; one item is taken
//   when in_valid_i is high and in_stall_o is low. The block works on one
//   item at a time and stalls input until the sequencer hands off its result.
// Output channel: out_valid_o / out_stall_i with is_prime_o and divisor_count_o
//   (0, 1, 2 or 3 meaning three or more); one item per candidate.
// Candidates 0 and 1 finish without the remainder unit. Otherwise each trial
//   divisor takes one pass through the bit-serial remainder unit, and divisors
//   run from 2 up to the square root; a composite stops at its smallest factor.
// The remainder unit sets the pace; a new candidate waits for the last result.
// The output register holds a finished item while the receiver stalls, and a
//   new candidate is accepted meanwhile; the next result waits in the sequencer.
// Reset (rst_ni low, asynchronous) drops any item in flight and clears
//   out_valid_o.
`default_nettype none
module trial_division_prime_test_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  is_prime_o,
  output logic [1:0]                            divisor_count_o
);

  tdpt_pkg::mod_req_t mod_req;
  tdpt_pkg::mod_rsp_t mod_rsp;
  tdpt_pkg::result_t  res;
  logic               seq_idle;
  logic               start;
  logic               take;
  logic               out_valid_q;
  logic               is_prime_q;
  logic [1:0]         count_q;

  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;
  // Load the output register when it is empty or being drained.
  assign take       = res.valid && (!out_valid_q || !out_stall_i);

  tdpt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .candidate_i (candidate_i),
    .take_i      (take),
    .idle_o      (seq_idle),
    .res_o       (res),
    .req_o       (mod_req),
    .rsp_i       (mod_rsp)
  );

  tdpt_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      is_prime_q <= res.is_prime;
      count_q    <= res.count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_prime_o      = is_prime_q;
  assign divisor_count_o = count_q;

endmodule
`default_nettype wire

### sv/tdpt_checker.sv
// Port-level checker for the prime tester, bound to the top level.
`default_nettype none
`include "trial_division_prime_test_top_macros.svh"
module tdpt_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic                             is_prime_o,
  input wire logic [1:0]                       divisor_count_o
);

  property p_out_hold;
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(is_prime_o) && $stable(divisor_count_o);
  endproperty

  property p_in_hold;
    in_valid_i && in_stall_o |=> in_valid_i && $stable(candidate_i);
  endproperty

  property p_prime_count;
    out_valid_o && is_prime_o |-> divisor_count_o == tdpt_pkg::COUNT_PRIME;
  endproperty

  property p_count_prime;
    out_valid_o && divisor_count_o == tdpt_pkg::COUNT_PRIME |-> is_prime_o;
  endproperty

  property p_busy_after_accept;
    in_valid_i && !in_stall_o |=> in_stall_o;
  endproperty

  `TDPT_ASSERT_CLK(a_out_hold, p_out_hold, "stalled output item changed")
  `TDPT_ASSERT_CLK(a_in_hold, p_in_hold, "stalled input item changed")
  `TDPT_ASSERT_CLK(a_prime_count, p_prime_count, "prime item without two divisors")
  `TDPT_ASSERT_CLK(a_count_prime, p_count_prime, "two divisors but not flagged prime")
  `TDPT_ASSERT_CLK(a_busy_after_accept, p_busy_after_accept, "input taken while busy")

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .candidate_i     (candidate_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .is_prime_o      (is_prime_o),
  .divisor_count_o (divisor_count_o)
);
`default_nettype wire

### tb/sv/trial_division_prime_test_top_test.sv
// Self-checking testbench for the trial-division prime tester.
`timescale 1ns / 1ps
module trial_division_prime_test_top_test;

  localparam int unsigned IDLE_PERCENT = 26;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned STUCK_LIMIT  = 40000;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned NUM_CORNERS  = 20;

  // Zero, one, tiny primes and composites, squares at the root bound, field extremes.
  localparam logic [tdpt_pkg::VALUE_WIDTH-1:0] CORNER_CASES [NUM_CORNERS] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd25, 16'd49,
    16'd97, 16'd121, 16'd63001, 16'd65025, 16'd65521, 16'd65519, 16'd65535, 16'd32768,
    16'hAAAA, 16'h5555, 16'd65497, 16'd32749
  };

  class prime_scoreboard;
    typedef struct packed {
      logic       is_prime;
      logic [1:0] count;
    } verdict_t;

    verdict_t    awaited[$];
    int unsigned failures   = 0;
    int unsigned checked    = 0;
    int unsigned primes     = 0;
    int unsigned composites = 0;
    int unsigned trivial    = 0;

    // Try divisors from 2 up to the square root; stop at the first factor.
    function logic [1:0] count_divisors(logic [tdpt_pkg::VALUE_WIDTH-1:0] n);
      int unsigned d;
      if (n == '0) return tdpt_pkg::COUNT_ZERO;
      if (n == tdpt_pkg::VALUE_WIDTH'(1)) return tdpt_pkg::COUNT_ONE;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return tdpt_pkg::COUNT_CAP;
      end
      return tdpt_pkg::COUNT_PRIME;
    endfunction

    function void note_candidate(logic [tdpt_pkg::VALUE_WIDTH-1:0] n);
      verdict_t v;
      v.count    = count_divisors(n);
      v.is_prime = (v.count == tdpt_pkg::COUNT_PRIME);
      if (v.count == tdpt_pkg::COUNT_PRIME) primes++;
      else if (v.count == tdpt_pkg::COUNT_CAP) composites++;
      else trivial++;
      awaited.insert(awaited.size(), v);
    endfunction

    function void check_result(logic is_prime, logic [1:0] count);
      verdict_t v;
      checked++;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: is_prime=%0d divisor_count=%0d",
               is_prime, count);
        failures++;
        return;
      end
      v = awaited.pop_front();
      if (is_prime !== v.is_prime) begin
        $error("is_prime: expected %0d, got %0d", v.is_prime, is_prime);
        failures++;
      end
      if (count !== v.count) begin
        $error("divisor_count: expected %0d, got %0d", v.count, count);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic [tdpt_pkg::VALUE_WIDTH-1:0] candidate_i = '0;
  logic                             out_stall_i = 1'b0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic                             is_prime_o;
  logic [1:0]                       divisor_count_o;

  prime_scoreboard verdicts = new;
  bit              idle_enabled = 1'b1;
  bit              hold_request = 1'b0;

  trial_division_prime_test_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .candidate_i     (candidate_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_prime_o      (is_prime_o),
    .divisor_count_o (divisor_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly small values; some full range, squares and values near the top.
  function automatic logic [tdpt_pkg::VALUE_WIDTH-1:0] random_candidate();
    int unsigned pick;
    int unsigned root;
    pick = $urandom_range(99);
    root = $urandom_range(255, 2);
    if (pick < 65) return tdpt_pkg::VALUE_WIDTH'($urandom_range(1023));
    if (pick < 82) return tdpt_pkg::VALUE_WIDTH'($urandom);
    if (pick < 94) return tdpt_pkg::VALUE_WIDTH'(root * root);
    return tdpt_pkg::VALUE_WIDTH'($urandom_range(65535, 65000));
  endfunction

  task automatic send_candidate(input logic [tdpt_pkg::VALUE_WIDTH-1:0] value);
    while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    verdicts.note_candidate(value);
  endtask

  // Drop valid and wait for every outstanding item to come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdicts.pending() != 0);
  endtask

  // Receiver: check each accepted item, then draw the next stall.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        verdicts.check_result(is_prime_o, divisor_count_o);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= idle_enabled && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Watchdog: give up after too long without any item moving.
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
    $display("trial_division_prime_test_top: mismatch");
    $finish;
  end

  initial begin
    int unsigned i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_CORNERS; i++) send_candidate(CORNER_CASES[i]);
    drain_results();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // Run a stretch with no idling on either side.
      if (i == 40) idle_enabled = 1'b0;
      if (i == 70) idle_enabled = 1'b1;
      if (i == 80) begin
        // Stall the output and keep offering short items so the block backs up.
        hold_request = 1'b1;
        repeat (8) send_candidate(tdpt_pkg::VALUE_WIDTH'($urandom_range(200)));
      end
      if (i == 100) drain_results();
      send_candidate(random_candidate());
    end

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("covered %0d candidates: %0d prime, %0d composite, %0d zero or one",
             verdicts.primes + verdicts.composites + verdicts.trivial,
             verdicts.primes, verdicts.composites, verdicts.trivial);
    $display("checked %0d results, with a %0d-cycle output hold and full drain pauses",
             verdicts.checked, HOLD_CYCLES);
    if (verdicts.failures == 0 && verdicts.pending() == 0) begin
      $display("trial_division_prime_test_top: match");
    end else begin
      $display("trial_division_prime_test_top: mismatch");
    end
    $finish;
  end

endmodule
